// File: rtl/avss_pkg.sv
package avss_pkg;

    // Field widths
    localparam int RISK_W   = 16;
    localparam int WARN_W   = 2;
    localparam int DT_W     = 20;
    localparam int DTC_W    = 17;   // clamped step time, 1000..100000
    localparam int STREAK_W = 5;
    localparam int CLEAR_W  = 4;
    localparam int SPEED_W  = 21;
    localparam int YAW_W    = 27;
    localparam int BRAKE_W  = 20;
    localparam int SLEW_W   = 29;   // signed working width of the slew limiter

    // Register map, index taken from paddr[3:2]
    localparam logic [1:0] REG_CENTRE_THR = 2'd0;
    localparam logic [1:0] REG_SIDE_THR   = 2'd1;
    localparam logic [1:0] REG_CONFIRM    = 2'd2;

    localparam logic [RISK_W-1:0]   CENTRE_THR_RST = 16'd5898;
    localparam logic [RISK_W-1:0]   SIDE_THR_RST   = 16'd21299;
    localparam logic [STREAK_W-1:0] CONFIRM_RST    = 5'd3;

    // Warning codes
    localparam logic [WARN_W-1:0] WARN_RED = 2'd2;

    // Streak and clear-frame counter limits
    localparam logic [STREAK_W-1:0]       STREAK_MAX    = 5'd30;
    localparam logic signed [CLEAR_W-1:0] CLEAR_HOLD    = 4'sd5;
    localparam logic signed [CLEAR_W-1:0] CLEAR_RESTART = -4'sd7;

    // Targets in micro units
    localparam logic [SPEED_W-1:0] SPEED_CRUISE   = 21'd2000000;
    localparam logic [SPEED_W-1:0] SPEED_TURN     = 21'd1350000;
    localparam logic [SPEED_W-1:0] SPEED_TURN_RED = 21'd650000;
    localparam logic [SPEED_W-1:0] SPEED_HOLD     = 21'd1000000;
    localparam logic [SPEED_W-1:0] SPEED_STOP     = 21'd0;
    localparam logic [BRAKE_W-1:0] BRAKE_FULL     = 20'd1000000;
    localparam logic [BRAKE_W-1:0] BRAKE_NONE     = 20'd0;
    localparam logic signed [YAW_W-1:0] YAW_TURN     = 27'sd45000000;
    localparam logic signed [YAW_W-1:0] YAW_TURN_RED = 27'sd60000000;

    // Step time clamp and slew rates per microsecond
    localparam logic [DT_W-1:0] DT_MIN_US  = 20'd1000;
    localparam logic [DT_W-1:0] DT_MAX_US  = 20'd100000;
    localparam int              SPEED_SLEW = 3;
    localparam int              YAW_SLEW   = 180;
    localparam int              BRAKE_SLEW = 4;

    // Turn direction, positive toward image left
    typedef enum logic [1:0] {
        TURN_NONE  = 2'b00,
        TURN_LEFT  = 2'b01,
        TURN_RIGHT = 2'b11
    } t_turn;

    // Per-word decision handed from the planner to the slew limiter and state
    typedef struct packed {
        logic [STREAK_W-1:0]       streak;
        logic signed [CLEAR_W-1:0] clear;
        t_turn                     turn;
        logic [SPEED_W-1:0]        speed_tgt;
        logic signed [YAW_W-1:0]   yaw_tgt;
        logic [BRAKE_W-1:0]        brake_tgt;
    } t_plan;

endpackage

// File: rtl/avss_decide.sv
module avss_decide (
    input  logic [avss_pkg::RISK_W-1:0]         i_risk_left,
    input  logic [avss_pkg::RISK_W-1:0]         i_risk_centre,
    input  logic [avss_pkg::RISK_W-1:0]         i_risk_right,
    input  logic [avss_pkg::WARN_W-1:0]         i_warning_level,
    input  logic [avss_pkg::RISK_W-1:0]         i_centre_thr,
    input  logic [avss_pkg::RISK_W-1:0]         i_side_thr,
    input  logic [avss_pkg::STREAK_W-1:0]       i_confirm,
    input  logic [avss_pkg::STREAK_W-1:0]       i_streak,
    input  logic signed [avss_pkg::CLEAR_W-1:0] i_clear,
    input  avss_pkg::t_turn                     i_turn,
    output avss_pkg::t_plan                     o_plan
);

    logic                                centre_act;
    logic                                blocked;
    logic                                red;
    logic                                stop;
    logic [avss_pkg::STREAK_W-1:0]       streak_n;
    logic signed [avss_pkg::CLEAR_W-1:0] clear_n;
    avss_pkg::t_turn                     want_turn;
    avss_pkg::t_turn                     turn_n;
    logic [avss_pkg::SPEED_W-1:0]        speed_tgt;
    logic [avss_pkg::BRAKE_W-1:0]        brake_tgt;
    logic signed [avss_pkg::YAW_W-1:0]   yaw_mag;
    logic signed [avss_pkg::YAW_W-1:0]   yaw_tgt;

    // Saturating centre streak, 0..30
    assign centre_act = i_risk_centre > i_centre_thr;
    always_comb begin
        streak_n = i_streak;
        if (centre_act) begin
            if (i_streak < avss_pkg::STREAK_MAX) streak_n = i_streak + 5'd1;
        end else if (i_streak != '0) begin
            streak_n = i_streak - 5'd1;
        end
    end

    assign blocked = streak_n >= i_confirm;
    assign red     = i_warning_level == avss_pkg::WARN_RED;
    assign stop    = (i_risk_left > i_side_thr) && (i_risk_right > i_side_thr);

    // Maneuver choice
    always_comb begin
        clear_n   = i_clear;
        want_turn = avss_pkg::TURN_NONE;
        speed_tgt = avss_pkg::SPEED_CRUISE;
        brake_tgt = avss_pkg::BRAKE_NONE;
        if (blocked) begin
            clear_n = avss_pkg::CLEAR_RESTART;
            if (stop) begin
                speed_tgt = avss_pkg::SPEED_STOP;
                brake_tgt = avss_pkg::BRAKE_FULL;
            end else begin
                // ties turn right
                want_turn = (i_risk_left < i_risk_right) ? avss_pkg::TURN_LEFT
                                                         : avss_pkg::TURN_RIGHT;
                speed_tgt = red ? avss_pkg::SPEED_TURN_RED : avss_pkg::SPEED_TURN;
            end
        end else begin
            if (i_clear < avss_pkg::CLEAR_HOLD) clear_n = i_clear + 4'sd1;
            if (clear_n < avss_pkg::CLEAR_HOLD) begin
                want_turn = i_turn;
                if (i_turn != avss_pkg::TURN_NONE) speed_tgt = avss_pkg::SPEED_HOLD;
            end
        end
    end

    // Turn memory: keep until the clear hold runs out
    always_comb begin
        turn_n = i_turn;
        if (want_turn != avss_pkg::TURN_NONE)     turn_n = want_turn;
        else if (clear_n >= avss_pkg::CLEAR_HOLD) turn_n = avss_pkg::TURN_NONE;
    end

    // Yaw target from the stored turn
    assign yaw_mag = (blocked && red) ? avss_pkg::YAW_TURN_RED : avss_pkg::YAW_TURN;
    always_comb begin
        unique case (turn_n)
            avss_pkg::TURN_LEFT:  yaw_tgt = yaw_mag;
            avss_pkg::TURN_RIGHT: yaw_tgt = -yaw_mag;
            default:              yaw_tgt = '0;
        endcase
    end

    always_comb begin
        o_plan.streak    = streak_n;
        o_plan.clear     = clear_n;
        o_plan.turn      = turn_n;
        o_plan.speed_tgt = speed_tgt;
        o_plan.yaw_tgt   = yaw_tgt;
        o_plan.brake_tgt = brake_tgt;
    end

endmodule

// File: rtl/avss_slew.sv
module avss_slew (
    input  logic [avss_pkg::DT_W-1:0]           i_step_time_us,
    input  avss_pkg::t_plan                     i_plan,
    input  logic [avss_pkg::SPEED_W-1:0]        i_speed_now,
    input  logic signed [avss_pkg::YAW_W-1:0]   i_yaw_now,
    input  logic [avss_pkg::BRAKE_W-1:0]        i_brake_now,
    output logic [avss_pkg::SPEED_W-1:0]        o_speed,
    output logic signed [avss_pkg::YAW_W-1:0]   o_yaw,
    output logic [avss_pkg::BRAKE_W-1:0]        o_brake
);

    localparam int SW = avss_pkg::SLEW_W;

    logic [avss_pkg::DT_W-1:0]  dt_clamp;
    logic [avss_pkg::DTC_W-1:0] dtc;
    logic [18:0]                step_speed;
    logic [24:0]                step_yaw;
    logic [18:0]                step_brake;
    logic signed [SW-1:0]       speed_sum;
    logic signed [SW-1:0]       yaw_sum;
    logic signed [SW-1:0]       brake_sum;

    // Move now toward target by at most step
    function automatic logic signed [SW-1:0] slew_to(
        input logic signed [SW-1:0] now,
        input logic signed [SW-1:0] tgt,
        input logic signed [SW-1:0] stp
    );
        logic signed [SW-1:0] d;
        d = tgt - now;
        if (d > stp)       d = stp;
        else if (d < -stp) d = -stp;
        return now + d;
    endfunction

    // Clamp step time to 1 ms .. 100 ms
    always_comb begin
        dt_clamp = i_step_time_us;
        if (i_step_time_us < avss_pkg::DT_MIN_US)      dt_clamp = avss_pkg::DT_MIN_US;
        else if (i_step_time_us > avss_pkg::DT_MAX_US) dt_clamp = avss_pkg::DT_MAX_US;
    end
    assign dtc = dt_clamp[avss_pkg::DTC_W-1:0];

    // Per-step limits, constant multiplies
    assign step_speed = 19'(dtc) * 19'(avss_pkg::SPEED_SLEW);
    assign step_yaw   = 25'(dtc) * 25'(avss_pkg::YAW_SLEW);
    assign step_brake = 19'(dtc) * 19'(avss_pkg::BRAKE_SLEW);

    assign speed_sum = slew_to($signed(SW'(i_speed_now)),
                               $signed(SW'(i_plan.speed_tgt)),
                               $signed(SW'(step_speed)));
    assign yaw_sum   = slew_to(SW'(i_yaw_now),
                               SW'(i_plan.yaw_tgt),
                               $signed(SW'(step_yaw)));
    assign brake_sum = slew_to($signed(SW'(i_brake_now)),
                               $signed(SW'(i_plan.brake_tgt)),
                               $signed(SW'(step_brake)));

    assign o_speed = speed_sum[avss_pkg::SPEED_W-1:0];
    assign o_yaw   = yaw_sum[avss_pkg::YAW_W-1:0];
    assign o_brake = brake_sum[avss_pkg::BRAKE_W-1:0];

endmodule

// File: rtl/avoidance_steering_slew.sv
// Channel  | Dir | Handshake          | Contents
// s_axis   | in  | tvalid / tready    | risks, warning level, step time (72-bit tdata)
// m_axis   | out | tvalid / tready    | speed, yaw rate, brake commands (72-bit tdata)
// apb      | in  | psel/penable/pready| thresholds and confirm count, 0x0 / 0x4 / 0x8
//
// One word per cycle sustained while the output is not stalled; a word taken
// into the input register passes through the decision and slew logic, a
// single stage, into the result register.
// The steering state updates on the same edge the result register loads.
// Synchronous reset clears the state and restores the register defaults.
// A stalled output keeps its word; the input register still takes a new
// word in that cycle only if it is empty.
module avoidance_steering_slew (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [15:0] risk_left, [31:16] risk_centre, [47:32] risk_right,
    // [49:48] warning_level, [69:50] step_time_us, [71:70] zero
    input  logic [71:0] i_s_axis_tdata,
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [20:0] speed_um_s, [47:21] yaw_rate_udeg_s, [67:48] brake_micro, [71:68] zero
    output logic [71:0] o_m_axis_tdata,
    // configuration
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    // Configuration registers
    logic [avss_pkg::RISK_W-1:0]   r_centre_thr;
    logic [avss_pkg::RISK_W-1:0]   r_side_thr;
    logic [avss_pkg::STREAK_W-1:0] r_confirm;
    logic                          cfg_wr;

    // Input register
    logic                          r_in_valid;
    logic [69:0]                   r_in_data;
    logic                          move;

    // Steering state
    logic [avss_pkg::STREAK_W-1:0]       r_streak;
    logic signed [avss_pkg::CLEAR_W-1:0] r_clear;
    avss_pkg::t_turn                     r_turn;
    logic [avss_pkg::SPEED_W-1:0]        r_speed;
    logic signed [avss_pkg::YAW_W-1:0]   r_yaw;
    logic [avss_pkg::BRAKE_W-1:0]        r_brake;

    // Result register
    logic                                r_out_valid;
    logic [67:0]                         r_out_data;

    avss_pkg::t_plan                     plan;
    logic [avss_pkg::SPEED_W-1:0]        n_speed;
    logic signed [avss_pkg::YAW_W-1:0]   n_yaw;
    logic [avss_pkg::BRAKE_W-1:0]        n_brake;

    // APB register file
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre_thr <= avss_pkg::CENTRE_THR_RST;
            r_side_thr   <= avss_pkg::SIDE_THR_RST;
            r_confirm    <= avss_pkg::CONFIRM_RST;
        end else if (cfg_wr) begin
            unique case (i_paddr[3:2])
                avss_pkg::REG_CENTRE_THR: r_centre_thr <= i_pwdata[avss_pkg::RISK_W-1:0];
                avss_pkg::REG_SIDE_THR:   r_side_thr   <= i_pwdata[avss_pkg::RISK_W-1:0];
                avss_pkg::REG_CONFIRM:    r_confirm    <= i_pwdata[avss_pkg::STREAK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_paddr[3:2])
            avss_pkg::REG_CENTRE_THR: o_prdata = 32'(r_centre_thr);
            avss_pkg::REG_SIDE_THR:   o_prdata = 32'(r_side_thr);
            avss_pkg::REG_CONFIRM:    o_prdata = 32'(r_confirm);
            default:                  o_prdata = '0;
        endcase
    end

    // Stage handshake
    assign move            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_data <= i_s_axis_tdata[69:0];
        end
    end

    // Decision and slew logic
    avss_decide u_decide (
        .i_risk_left     (r_in_data[15:0]),
        .i_risk_centre   (r_in_data[31:16]),
        .i_risk_right    (r_in_data[47:32]),
        .i_warning_level (r_in_data[49:48]),
        .i_centre_thr    (r_centre_thr),
        .i_side_thr      (r_side_thr),
        .i_confirm       (r_confirm),
        .i_streak        (r_streak),
        .i_clear         (r_clear),
        .i_turn          (r_turn),
        .o_plan          (plan)
    );

    avss_slew u_slew (
        .i_step_time_us (r_in_data[69:50]),
        .i_plan         (plan),
        .i_speed_now    (r_speed),
        .i_yaw_now      (r_yaw),
        .i_brake_now    (r_brake),
        .o_speed        (n_speed),
        .o_yaw          (n_yaw),
        .o_brake        (n_brake)
    );

    // State update, one per word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_streak <= '0;
            r_clear  <= '0;
            r_turn   <= avss_pkg::TURN_NONE;
            r_speed  <= '0;
            r_yaw    <= '0;
            r_brake  <= '0;
        end else if (move) begin
            r_streak <= plan.streak;
            r_clear  <= plan.clear;
            r_turn   <= plan.turn;
            r_speed  <= n_speed;
            r_yaw    <= n_yaw;
            r_brake  <= n_brake;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_data <= {n_brake, n_yaw, n_speed};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out_data};

    // Checks
    a_streak_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_streak <= avss_pkg::STREAK_MAX)
        else $error("centre streak above saturation");

    a_clear_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_clear >= avss_pkg::CLEAR_RESTART) && (r_clear <= avss_pkg::CLEAR_HOLD))
        else $error("clear counter out of range");

    a_cmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_speed <= avss_pkg::SPEED_CRUISE) && (r_brake <= avss_pkg::BRAKE_FULL))
        else $error("speed or brake state beyond its target range");

    a_stall_keeps_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !move) |=> (r_in_valid && $stable(r_in_data)))
        else $error("input word lost while result stage stalled");

    a_state_tracks_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> (r_out_data == {r_brake, r_yaw, r_speed}))
        else $error("result word differs from updated state");

endmodule

// File: dv/tb_avoidance_steering_slew.sv
`timescale 1ns / 100ps

module tb_avoidance_steering_slew;

    // Command targets and limits, micro units
    localparam longint TGT_CRUISE   = 2000000;
    localparam longint TGT_TURN     = 1350000;
    localparam longint TGT_TURN_RED = 650000;
    localparam longint TGT_HOLD     = 1000000;
    localparam longint TGT_BRAKE    = 1000000;
    localparam longint YAW_MAG      = 45000000;
    localparam longint YAW_MAG_RED  = 60000000;
    localparam longint DT_LO        = 1000;
    localparam longint DT_HI        = 100000;
    localparam longint RATE_SPEED   = 3;
    localparam longint RATE_YAW     = 180;
    localparam longint RATE_BRAKE   = 4;
    localparam int     STREAK_TOP   = 30;
    localparam int     HOLD_FRAMES  = 5;
    localparam int     CLEAR_RELOAD = -7;
    localparam logic [avss_pkg::WARN_W-1:0] WARN_CODE_RED = 2'd2;

    // Centre-risk shapes for random frames
    localparam int MODE_LOW  = 0;
    localparam int MODE_HIGH = 1;
    localparam int MODE_ANY  = 2;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [avss_pkg::RISK_W-1:0] left;
        logic [avss_pkg::RISK_W-1:0] centre;
        logic [avss_pkg::RISK_W-1:0] right;
        logic [avss_pkg::WARN_W-1:0] warn;
        logic [avss_pkg::DT_W-1:0]   dt;
    } t_frame;

    typedef struct {
        logic [avss_pkg::SPEED_W-1:0]      speed;
        logic signed [avss_pkg::YAW_W-1:0] yaw;
        logic [avss_pkg::BRAKE_W-1:0]      brake;
    } t_cmd;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [71:0] s_tdata = '0;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;

    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [71:0] o_m_axis_tdata;
    logic [31:0] o_prdata;
    logic        o_pready;

    // Steering model: registers and state
    logic [avss_pkg::RISK_W-1:0]   cthr_m;
    logic [avss_pkg::RISK_W-1:0]   sthr_m;
    logic [avss_pkg::STREAK_W-1:0] confirm_m;
    int                            streak_m;
    int                            clear_m;
    avss_pkg::t_turn               turn_hold;
    longint                        speed_m;
    longint                        yaw_m;
    longint                        brake_m;

    t_cmd pending_cmds[$];
    int   errors = 0;
    int   idle_cycles = 0;
    bit   src_burst = 1'b0;
    bit   snk_burst = 1'b0;

    always #10 clk = ~clk;

    avoidance_steering_slew dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_prdata        (o_prdata),
        .o_pready        (o_pready)
    );

    function automatic longint slew_to(longint cur, longint tgt, longint lim);
        longint d;
        d = tgt - cur;
        if (d > lim) d = lim;
        if (d < -lim) d = -lim;
        return cur + d;
    endfunction

    // Advance the steering model by one frame, return the command word
    function automatic t_cmd steer_next(t_frame f);
        logic            blocked;
        logic            red;
        avss_pkg::t_turn want_turn;
        longint          want_speed;
        longint          want_brake;
        longint          want_yaw;
        longint          mag;
        longint          dt;
        t_cmd            c;
        red = (f.warn == WARN_CODE_RED);
        want_turn = avss_pkg::TURN_NONE;
        want_speed = TGT_CRUISE;
        want_brake = 0;

        // saturating centre streak
        if (f.centre > cthr_m) begin
            if (streak_m < STREAK_TOP) streak_m++;
        end else if (streak_m > 0) begin
            streak_m--;
        end
        blocked = (streak_m >= int'(confirm_m));

        if (blocked) begin
            clear_m = CLEAR_RELOAD;
            if (f.left > sthr_m && f.right > sthr_m) begin
                want_speed = 0;
                want_brake = TGT_BRAKE;
            end else begin
                want_turn = (f.left < f.right) ? avss_pkg::TURN_LEFT : avss_pkg::TURN_RIGHT;
                want_speed = red ? TGT_TURN_RED : TGT_TURN;
            end
        end else begin
            if (clear_m < HOLD_FRAMES) clear_m++;
            if (clear_m < HOLD_FRAMES) begin
                want_turn = turn_hold;
                if (turn_hold != avss_pkg::TURN_NONE) want_speed = TGT_HOLD;
            end
        end

        // turn memory
        if (want_turn != avss_pkg::TURN_NONE) turn_hold = want_turn;
        else if (clear_m >= HOLD_FRAMES) turn_hold = avss_pkg::TURN_NONE;

        mag = (blocked && red) ? YAW_MAG_RED : YAW_MAG;
        unique case (turn_hold)
            avss_pkg::TURN_LEFT:  want_yaw = mag;
            avss_pkg::TURN_RIGHT: want_yaw = -mag;
            default:              want_yaw = 0;
        endcase

        dt = longint'(f.dt);
        if (dt < DT_LO) dt = DT_LO;
        if (dt > DT_HI) dt = DT_HI;

        speed_m = slew_to(speed_m, want_speed, RATE_SPEED * dt);
        yaw_m   = slew_to(yaw_m, want_yaw, RATE_YAW * dt);
        brake_m = slew_to(brake_m, want_brake, RATE_BRAKE * dt);

        c.speed = speed_m[avss_pkg::SPEED_W-1:0];
        c.yaw   = yaw_m[avss_pkg::YAW_W-1:0];
        c.brake = brake_m[avss_pkg::BRAKE_W-1:0];
        return c;
    endfunction

    function automatic t_frame frame(int l, int c, int r, int w, int dt);
        t_frame f;
        f.left = 16'(l);
        f.centre = 16'(c);
        f.right = 16'(r);
        f.warn = 2'(w);
        f.dt = 20'(dt);
        return f;
    endfunction

    // Random frame; mode picks centre below, above or anywhere vs. threshold
    function automatic t_frame random_frame(int mode);
        t_frame f;
        int     m;
        m = (mode == MODE_ANY) ? $urandom_range(0, 1) : mode;
        if (mode == MODE_ANY && $urandom_range(0, 1) == 0)
            f.centre = 16'($urandom_range(0, 65535));
        else if (m == MODE_HIGH)
            f.centre = (cthr_m == 16'hFFFF) ? 16'hFFFF
                                            : 16'($urandom_range(65535, int'(cthr_m) + 1));
        else
            f.centre = 16'($urandom_range(int'(cthr_m), 0));

        case ($urandom_range(0, 9))
            0, 1: begin
                // both sides high: stop case
                f.left  = (sthr_m == 16'hFFFF) ? 16'hFFFF
                                               : 16'($urandom_range(65535, int'(sthr_m) + 1));
                f.right = (sthr_m == 16'hFFFF) ? 16'hFFFF
                                               : 16'($urandom_range(65535, int'(sthr_m) + 1));
            end
            2: begin
                f.left  = 16'($urandom_range(0, 32768));
                f.right = f.left;
            end
            3: begin
                f.left  = 16'($urandom_range(0, 65535));
                f.right = 16'($urandom_range(0, 65535));
            end
            default: begin
                f.left  = 16'($urandom_range(0, 32768));
                f.right = 16'($urandom_range(0, 32768));
            end
        endcase

        f.warn = ($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, 2));

        case ($urandom_range(0, 7))
            0:       f.dt = 20'($urandom_range(0, 20'hFFFFF));
            1:       f.dt = 20'($urandom_range(0, 1000));
            default: f.dt = 20'($urandom_range(1000, 100000));
        endcase
        return f;
    endfunction

    // Send one frame; tvalid stays up after the handshake for back-to-back words
    task automatic send_frame(t_frame f);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, f.dt, f.warn, f.right, f.centre, f.left};
        do @(posedge clk); while (!o_s_axis_tready);
        pending_cmds.insert(pending_cmds.size(), steer_next(f));
    endtask

    // Stop sending and wait for every outstanding command
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!o_pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            avss_pkg::REG_CENTRE_THR: cthr_m = val[avss_pkg::RISK_W-1:0];
            avss_pkg::REG_SIDE_THR:   sthr_m = val[avss_pkg::RISK_W-1:0];
            avss_pkg::REG_CONFIRM:    confirm_m = val[avss_pkg::STREAK_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apb_check(logic [1:0] idx, logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!o_pready);
        if (o_prdata !== want) begin
            $error("prdata[reg %0d]: expected %0d, got %0d", idx, want, o_prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_limits(int cthr, int sthr, int confirm);
        drain_results();
        apb_write(avss_pkg::REG_CENTRE_THR, cthr);
        apb_write(avss_pkg::REG_SIDE_THR, sthr);
        apb_write(avss_pkg::REG_CONFIRM, confirm);
        apb_check(avss_pkg::REG_CENTRE_THR, {16'd0, cthr_m});
        apb_check(avss_pkg::REG_SIDE_THR, {16'd0, sthr_m});
        apb_check(avss_pkg::REG_CONFIRM, {27'd0, confirm_m});
    endtask

    // Runs of blocked frames, clear frames and noise, with idling changes
    task automatic run_episodes(int n_items);
        int done;
        int kind;
        int len;
        int mode;
        done = 0;
        while (done < n_items) begin
            kind = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0) src_burst = !src_burst;
            if ($urandom_range(0, 3) == 0) snk_burst = !snk_burst;
            if (kind < 4) begin
                len = $urandom_range(1, 40);
                mode = MODE_HIGH;
            end else if (kind < 8) begin
                len = $urandom_range(1, 15);
                mode = MODE_LOW;
            end else begin
                len = $urandom_range(1, 10);
                mode = MODE_ANY;
            end
            repeat (len) begin
                send_frame(random_frame(mode));
                done++;
            end
        end
    endtask

    task automatic test_register_defaults();
        apb_check(avss_pkg::REG_CENTRE_THR, 32'd5898);
        apb_check(avss_pkg::REG_SIDE_THR, 32'd21299);
        apb_check(avss_pkg::REG_CONFIRM, 32'd3);
    endtask

    // Field extremes, threshold edges, stop, both turns, ties, hold and release
    task automatic test_directed_frames();
        src_burst = 1'b1;
        snk_burst = 1'b1;
        send_frame(frame(0, 0, 0, 0, 0));
        send_frame(frame(0, 5898, 0, 1, 1000));
        send_frame(frame(100, 5899, 200, 2, 999));
        send_frame(frame(65535, 65535, 65535, 3, 20'hFFFFF));
        send_frame(frame(32768, 32768, 32768, 2, 100000));
        send_frame(frame(21299, 40000, 21300, 2, 100001));
        send_frame(frame(9000, 40000, 9000, 1, 50000));
        send_frame(frame(30000, 40000, 100, 3, 77777));
        send_frame(frame(100, 40000, 30000, 0, 100000));
        repeat (12) send_frame(frame(0, 0, 0, 0, 20000));
        send_frame(frame(0, 0, 0, 2, 20'hFFFFF));
        send_frame(frame(65535, 0, 0, 0, 1));
        src_burst = 1'b0;
        snk_burst = 1'b0;
        send_frame(frame(0, 0, 65535, 1, 100000));
    endtask

    // Register extremes, confirm count zero and out-of-range values
    task automatic test_threshold_sweep();
        set_limits(0, 0, 1);
        run_episodes(80);
        set_limits(65535, 65535, 31);
        run_episodes(80);
        set_limits(32768, 32768, 0);
        run_episodes(80);
        set_limits(1000, 30000, 30);
        run_episodes(80);
        set_limits($urandom_range(0, 32768), $urandom_range(0, 32768),
                   $urandom_range(1, 30));
        run_episodes(80);
        set_limits(5898, 21299, 3);
        run_episodes(80);
    endtask

    // Long random traffic with one full drain in the middle
    task automatic test_random_traffic();
        run_episodes(650);
        drain_results();
        run_episodes(650);
    endtask

    // Result checker with random sink stalls
    initial begin
        int   stall;
        t_cmd got;
        t_cmd want;
        while (!rst_n) @(posedge clk);
        forever begin
            stall = snk_burst ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!o_m_axis_tvalid);
            got.speed = o_m_axis_tdata[20:0];
            got.yaw   = o_m_axis_tdata[47:21];
            got.brake = o_m_axis_tdata[67:48];
            if (pending_cmds.size() == 0) begin
                $error("unexpected result word: speed %0d yaw %0d brake %0d",
                       got.speed, got.yaw, got.brake);
                errors++;
            end else begin
                want = pending_cmds.pop_front();
                if (got.speed !== want.speed) begin
                    $error("speed_um_s: expected %0d, got %0d", want.speed, got.speed);
                    errors++;
                end
                if (got.yaw !== want.yaw) begin
                    $error("yaw_rate_udeg_s: expected %0d, got %0d", want.yaw, got.yaw);
                    errors++;
                end
                if (got.brake !== want.brake) begin
                    $error("brake_micro: expected %0d, got %0d", want.brake, got.brake);
                    errors++;
                end
            end
        end
    end

    // Watchdog: cycles without any word moving on either side
    always @(posedge clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        cthr_m    = 16'd5898;
        sthr_m    = 16'd21299;
        confirm_m = 5'd3;
        streak_m  = 0;
        clear_m   = 0;
        turn_hold = avss_pkg::TURN_NONE;
        speed_m   = 0;
        yaw_m     = 0;
        brake_m   = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_defaults();
        test_directed_frames();
        test_threshold_sweep();
        test_random_traffic();

        drain_results();
        repeat (8) @(posedge clk);
        if (pending_cmds.size() != 0) begin
            $error("%0d result words never arrived", pending_cmds.size());
            errors++;
        end
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
